// File: sv/anxb_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// anxb_pkg
// Types and constants shared by the Annex B unit extractor front, queue and
// back end.
// ---------------------------------------------------------------------------
package anxb_pkg;

	localparam int BYTE_W      = 8;
	localparam int STAMP_W     = 33;
	localparam int POS_FIELD_W = 24;

	// command queue between front and back end; depth must be a power of two
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	localparam logic [BYTE_W-1:0] BYTE_ZERO = 8'h00;
	localparam logic [BYTE_W-1:0] BYTE_ONE  = 8'h01;
	localparam logic [BYTE_W-1:0] BYTE_EMU  = 8'h03;

	localparam logic MODE_DATA  = 1'b0;
	localparam logic MODE_FLUSH = 1'b1;

	typedef enum logic [1:0] {
		KIND_PAYLOAD = 2'd0,
		KIND_DONE    = 2'd1,
		KIND_REMOVED = 2'd2,
		KIND_ABANDON = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		PH_SEARCH0 = 3'd0,
		PH_SEARCH1 = 3'd1,
		PH_SEARCH2 = 3'd2,
		PH_HDR0    = 3'd3,
		PH_HDR1    = 3'd4,
		PH_BODY    = 3'd5,
		PH_ZERO1   = 3'd6,
		PH_ZERO2   = 3'd7
	} phase_t;

	// At most one command per input item: some pending zero bytes, then an
	// optional tail beat of the given kind.
	typedef struct packed {
		logic [1:0]             zeros;
		logic                   tail_en;
		kind_t                  tail_kind;
		logic [BYTE_W-1:0]      tail_byte;
		logic [POS_FIELD_W-1:0] pos;
		logic [STAMP_W-1:0]     stamp;
	} cmd_t;

endpackage

// File: sv/anxb_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// anxb_in_if / anxb_out_if
// Valid/ready channels for raw stream beats and extracted result beats.
// ---------------------------------------------------------------------------
interface anxb_in_if;
	import anxb_pkg::*;

	logic               valid;
	logic               ready;
	logic               mode;
	logic [BYTE_W-1:0]  data_byte;
	logic [STAMP_W-1:0] time_stamp;

	modport source (output valid, mode, data_byte, time_stamp, input ready);
	modport sink   (input valid, mode, data_byte, time_stamp, output ready);
endinterface

interface anxb_out_if;
	import anxb_pkg::*;

	logic                   valid;
	logic                   ready;
	logic [1:0]             kind;
	logic [BYTE_W-1:0]      payload;
	logic [POS_FIELD_W-1:0] removed_position;
	logic [STAMP_W-1:0]     unit_stamp;
	logic                   last;

	modport source (output valid, kind, payload, removed_position, unit_stamp, last,
		input ready);
	modport sink   (input valid, kind, payload, removed_position, unit_stamp, last,
		output ready);
endinterface

// File: sv/anxb_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// anxb_front
// Start-code scanner: takes one stream beat per cycle while push_ready is high,
// tracks unit state and counters, and turns each beat into at most one back-end command.
// ---------------------------------------------------------------------------
module anxb_front #(
	parameter int POSITION_BITS = 24
) (
	input  logic          clk,
	input  logic          arst_n,
	anxb_in_if.sink       bytes,
	output logic          push_valid,
	input  logic          push_ready,
	output anxb_pkg::cmd_t push_cmd
);
	import anxb_pkg::*;

	localparam int EXT_W = (POSITION_BITS > POS_FIELD_W) ? POSITION_BITS : POS_FIELD_W;
	localparam logic [POSITION_BITS-1:0] COUNT_MAX = {POSITION_BITS{1'b1}};

	phase_t                   phase_q, phase_d;
	logic                     unit_open_q, unit_open_d;
	logic [POSITION_BITS-1:0] written_q, written_d;
	logic [POSITION_BITS-1:0] removed_q, removed_d;
	logic [STAMP_W-1:0]       stamp_q, stamp_d;

	logic                     fire;
	logic                     emit;
	logic                     clear_cnt;
	logic                     removed_inc;
	logic                     removed_clr;
	logic [1:0]               nbytes;
	cmd_t                     cmd;

	logic [POSITION_BITS-1:0] w_eff;
	logic [POSITION_BITS-1:0] r_eff;
	logic [STAMP_W-1:0]       stamp_eff;
	logic [POSITION_BITS:0]   w_sum;
	logic [POSITION_BITS:0]   r_sum;
	logic [POSITION_BITS+1:0] pos_sum;
	logic [POSITION_BITS-1:0] pos_sat;
	logic [EXT_W-1:0]         pos_ext;

	assign fire        = bytes.valid && bytes.ready;
	assign bytes.ready = push_ready;
	assign push_valid  = fire && emit;
	assign push_cmd    = cmd;

	// a data beat with no open unit opens one with cleared counters
	assign w_eff     = unit_open_q ? written_q : '0;
	assign r_eff     = unit_open_q ? removed_q : '0;
	assign stamp_eff = unit_open_q ? stamp_q : bytes.time_stamp;

	// two zeros are counted before the removed byte's position is taken:
	// min(w + 2 + r, max) equals the chained saturating form
	assign pos_sum = {2'b00, w_eff} + {2'b00, r_eff} + (POSITION_BITS+2)'(2);
	assign pos_sat = (pos_sum > {2'b00, COUNT_MAX}) ? COUNT_MAX :
		pos_sum[POSITION_BITS-1:0];
	assign pos_ext = EXT_W'(pos_sat);

	assign w_sum = {1'b0, w_eff} + (POSITION_BITS+1)'(nbytes);
	assign r_sum = {1'b0, r_eff} + (POSITION_BITS+1)'(1);

	// next scan phase
	always_comb begin
		phase_d = phase_q;
		if (bytes.mode == MODE_FLUSH) begin
			phase_d = PH_SEARCH0;
		end else begin
			unique case (phase_q)
				PH_SEARCH0: phase_d = (bytes.data_byte == BYTE_ZERO) ? PH_SEARCH1 : PH_SEARCH0;
				PH_SEARCH1: phase_d = (bytes.data_byte == BYTE_ZERO) ? PH_SEARCH2 : PH_SEARCH0;
				PH_SEARCH2: begin
					if (bytes.data_byte == BYTE_ONE) begin
						phase_d = PH_HDR0;
					end else if (bytes.data_byte != BYTE_ZERO) begin
						phase_d = PH_SEARCH0;
					end
				end
				PH_HDR0:    phase_d = PH_HDR1;
				PH_HDR1:    phase_d = PH_BODY;
				PH_BODY:    phase_d = (bytes.data_byte == BYTE_ZERO) ? PH_ZERO1 : PH_BODY;
				PH_ZERO1:   phase_d = (bytes.data_byte == BYTE_ZERO) ? PH_ZERO2 : PH_BODY;
				PH_ZERO2: begin
					if (bytes.data_byte == BYTE_ZERO) begin
						phase_d = PH_ZERO2;
					end else if (bytes.data_byte == BYTE_ONE) begin
						phase_d = PH_HDR0;
					end else begin
						phase_d = PH_BODY;
					end
				end
				default:    phase_d = PH_SEARCH0;
			endcase
		end
	end

	// command and unit bookkeeping
	always_comb begin
		cmd           = '0;
		cmd.tail_kind = KIND_PAYLOAD;
		cmd.tail_byte = bytes.data_byte;
		cmd.pos       = pos_ext[POS_FIELD_W-1:0];
		cmd.stamp     = stamp_eff;
		emit          = 1'b0;
		nbytes        = 2'd0;
		clear_cnt     = 1'b0;
		removed_inc   = 1'b0;
		removed_clr   = 1'b0;
		unit_open_d   = unit_open_q;
		stamp_d       = stamp_eff;

		if (bytes.mode == MODE_FLUSH) begin
			unit_open_d = 1'b0;
			clear_cnt   = 1'b1;
			stamp_d     = stamp_q;
			emit        = unit_open_q;
			cmd.tail_en = 1'b1;
			if (phase_q == PH_BODY || phase_q == PH_ZERO1 || phase_q == PH_ZERO2) begin
				cmd.tail_kind = KIND_DONE;
				cmd.zeros     = (phase_q == PH_ZERO2) ? 2'd2 :
					(phase_q == PH_ZERO1) ? 2'd1 : 2'd0;
			end else begin
				cmd.tail_kind = KIND_ABANDON;
			end
		end else begin
			unit_open_d = 1'b1;
			unique case (phase_q)
				PH_SEARCH0, PH_SEARCH1: ;
				PH_SEARCH2: removed_clr = (bytes.data_byte == BYTE_ONE);
				PH_HDR0, PH_HDR1: begin
					emit        = 1'b1;
					cmd.tail_en = 1'b1;
					nbytes      = 2'd1;
				end
				PH_BODY: begin
					if (bytes.data_byte != BYTE_ZERO) begin
						emit        = 1'b1;
						cmd.tail_en = 1'b1;
						nbytes      = 2'd1;
					end
				end
				PH_ZERO1: begin
					if (bytes.data_byte != BYTE_ZERO) begin
						emit        = 1'b1;
						cmd.zeros   = 2'd1;
						cmd.tail_en = 1'b1;
						nbytes      = 2'd2;
					end
				end
				PH_ZERO2: begin
					emit = 1'b1;
					if (bytes.data_byte == BYTE_ZERO) begin
						// run of zeros: release the oldest one
						cmd.zeros = 2'd1;
						nbytes    = 2'd1;
					end else if (bytes.data_byte == BYTE_EMU) begin
						cmd.zeros     = 2'd2;
						cmd.tail_en   = 1'b1;
						cmd.tail_kind = KIND_REMOVED;
						nbytes        = 2'd2;
						removed_inc   = 1'b1;
					end else if (bytes.data_byte == BYTE_ONE) begin
						// start code ends this unit and opens the next
						cmd.tail_en   = 1'b1;
						cmd.tail_kind = KIND_DONE;
						stamp_d       = bytes.time_stamp;
						clear_cnt     = 1'b1;
					end else begin
						cmd.zeros   = 2'd2;
						cmd.tail_en = 1'b1;
						nbytes      = 2'd3;
					end
				end
				default: ;
			endcase
		end

		if (clear_cnt) begin
			written_d = '0;
			removed_d = '0;
		end else begin
			written_d = (w_sum > {1'b0, COUNT_MAX}) ? COUNT_MAX : w_sum[POSITION_BITS-1:0];
			if (removed_clr) begin
				removed_d = '0;
			end else if (removed_inc) begin
				removed_d = (r_sum > {1'b0, COUNT_MAX}) ? COUNT_MAX :
					r_sum[POSITION_BITS-1:0];
			end else begin
				removed_d = r_eff;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_SEARCH0;
			unit_open_q <= 1'b0;
			written_q   <= '0;
			removed_q   <= '0;
			stamp_q     <= '0;
		end else if (fire) begin
			phase_q     <= phase_d;
			unit_open_q <= unit_open_d;
			written_q   <= written_d;
			removed_q   <= removed_d;
			stamp_q     <= stamp_d;
		end
	end

	a_closed_searching: assert property (@(posedge clk) disable iff (!arst_n)
		!unit_open_q |-> phase_q == PH_SEARCH0)
		else $error("no unit open but scanner left the search phase");

	a_cmd_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		push_valid |-> (cmd.zeros != 2'd0 || cmd.tail_en))
		else $error("command pushed with no beats");

endmodule

// File: sv/anxb_queue.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// anxb_queue
// Short command queue that decouples the scanner from the result expander.
// ---------------------------------------------------------------------------
module anxb_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  anxb_pkg::cmd_t push_cmd,
	output logic           pop_valid,
	input  logic           pop_ready,
	output anxb_pkg::cmd_t pop_cmd
);
	import anxb_pkg::*;

	cmd_t              slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;
	logic              do_push;
	logic              do_pop;

	assign push_ready = (count_q != (QPTR_W+1)'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_cmd    = slot_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + (QPTR_W+1)'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - (QPTR_W+1)'(1);
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (QPTR_W+1)'(QUEUE_DEPTH))
		else $error("command queue overfilled");

endmodule

// File: sv/anxb_back.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// anxb_back
// Result expander: plays each command out as one to three result beats,
// pending zeros first, then the tail beat, with last on the final one.
// ---------------------------------------------------------------------------
module anxb_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           pop_valid,
	output logic           pop_ready,
	input  anxb_pkg::cmd_t pop_cmd,
	anxb_out_if.source     results
);
	import anxb_pkg::*;

	cmd_t       cmd_q;
	logic       cmd_vld_q;
	logic [1:0] idx_q;
	logic [1:0] total;
	logic       is_last;
	logic       in_zero;
	logic       fire;
	logic       load;
	kind_t      kind;

	assign total   = cmd_q.zeros + {1'b0, cmd_q.tail_en};
	assign is_last = (idx_q == total - 2'd1);
	assign in_zero = (idx_q < cmd_q.zeros);
	assign kind    = in_zero ? KIND_PAYLOAD : cmd_q.tail_kind;
	assign fire    = results.valid && results.ready;
	assign load    = !cmd_vld_q || (fire && is_last);

	assign pop_ready = load;

	assign results.valid            = cmd_vld_q;
	assign results.kind             = kind;
	assign results.payload          = (!in_zero && kind == KIND_PAYLOAD) ?
		cmd_q.tail_byte : BYTE_ZERO;
	assign results.removed_position = (kind == KIND_REMOVED) ? cmd_q.pos : '0;
	assign results.unit_stamp       = (kind == KIND_DONE) ? cmd_q.stamp : '0;
	assign results.last             = is_last;

	always_ff @(posedge clk) begin
		if (load) begin
			cmd_q <= pop_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_vld_q <= 1'b0;
			idx_q     <= '0;
		end else if (load) begin
			cmd_vld_q <= pop_valid;
			idx_q     <= '0;
		end else if (fire) begin
			idx_q <= idx_q + 2'd1;
		end
	end

	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_vld_q |-> idx_q < total)
		else $error("beat index ran past the command");

endmodule

// File: sv/annexb_nal_extractor_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// annexb_nal_extractor_top
// H.265 Annex B start-code scanner and emulation-prevention byte remover.
// ---------------------------------------------------------------------------
// The block takes one stream beat per cycle on bytes whenever the two-entry
// command queue has room, and each beat yields zero to three beats on results
// (payload bytes, removed-byte reports, unit complete or unit abandoned), the
// final one of an item flagged with last. The scanner turns a beat into a
// command in the cycle it is accepted; the expander drives one result beat
// per cycle from its command register while results are accepted, so a run
// of items with one result each flows at one item per cycle, while an item
// with three results holds the result port until all three are taken; the
// queue absorbs the input meanwhile. A command sits in a queue slot, then in
// the command register, before its results. No start-up pass after reset.
module annexb_nal_extractor_top #(
	parameter int POSITION_BITS = 24
) (
	input  logic       clk,
	input  logic       arst_n,
	anxb_in_if.sink    bytes,
	anxb_out_if.source results
);
	import anxb_pkg::*;

	logic push_valid;
	logic push_ready;
	cmd_t push_cmd;
	logic pop_valid;
	logic pop_ready;
	cmd_t pop_cmd;

	anxb_front #(
		.POSITION_BITS(POSITION_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.bytes      (bytes),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd)
	);

	anxb_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_cmd    (pop_cmd)
	);

	anxb_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_cmd   (pop_cmd),
		.results   (results)
	);

endmodule
